>>> src/qsd_pkg.sv
// shared types and constants for the queued step/direction pulse generator
`timescale 1ns / 1ps
`default_nettype none

package qsd_pkg;

  localparam int unsigned CMD_W   = 32;
  localparam int unsigned STEPS_W = 31;
  localparam int unsigned HALF_W  = 16;

  localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd10;

  typedef enum logic [1:0] {
    POST_NONE = 2'd0,
    POST_OK   = 2'd1,
    POST_FULL = 2'd2
  } post_status_t;

  // queue controls from the generator
  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctrl_t;

  // queue occupancy seen by the generator
  typedef struct packed {
    logic empty;
    logic full;
    logic last;
  } queue_stat_t;

endpackage

`default_nettype wire

>>> src/qsd_if.sv
// valid/ready channel interfaces for commands and results
`timescale 1ns / 1ps
`default_nettype none

interface qsd_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] step_count;

  modport source (output valid, output func, output step_count, input ready);
  modport sink   (input valid, input func, input step_count, output ready);
endinterface

interface qsd_out_if;
  logic       valid;
  logic       ready;
  logic       step_level;
  logic       dir_level;
  logic [1:0] post_status;
  logic       queue_empty;
  logic       generator_busy;

  modport source (output valid, output step_level, output dir_level, output post_status,
                  output queue_empty, output generator_busy, input ready);
  modport sink   (input valid, input step_level, input dir_level, input post_status,
                  input queue_empty, input generator_busy, output ready);
endinterface

`default_nettype wire

>>> src/queued_step_dir_pulse_generator_top.sv
// top level: step/direction pulse generator fed by a command queue
//
// Each transfer on the input channel is either a post (func = 1), which pushes a signed
// step count into a QUEUE_DEPTH entry fifo or is rejected when the fifo is full, or a
// tick (func = 0), which advances the pulse train by one time unit and, when no train is
// running, pops the next command. Every input transfer yields exactly one result, which
// carries the step and direction levels, the post status, the queue empty flag and the
// busy flag as they stand after that item. One item is taken per clock unless a result
// is stalled: the whole update is combinational from the state registers to the result
// register, and the queue head is prefetched from its ram so a pop never waits on the
// read port. The input is ready whenever the result register is empty or being drained
// in the same cycle. half_period_ticks is to be written through cfg_we/cfg_wdata only
// while the block is idle; the block does not enforce this. Zero counts as one tick.
`timescale 1ns / 1ps
`default_nettype none

module queued_step_dir_pulse_generator_top #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  qsd_in_if.sink           in_if,
  qsd_out_if.source        out_if,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  import qsd_pkg::*;

  logic [HALF_W-1:0]  half_r;
  logic [STEPS_W-1:0] steps_r, steps_nxt;
  logic [HALF_W-1:0]  phase_r, phase_nxt;
  logic               step_r, step_nxt;
  logic               dir_r, dir_nxt;

  logic               out_valid_r;
  logic               o_step_r, o_dir_r, o_empty_r, o_busy_r;
  post_status_t       o_status_r, status;
  logic               empty_after;

  queue_ctrl_t        qctrl;
  queue_stat_t        qstat;
  logic [CMD_W-1:0]   head;
  logic               in_xfer;

  logic [HALF_W-1:0]  phase_len;
  logic [CMD_W-1:0]   neg_raw;
  logic [STEPS_W-1:0] mag;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_xfer     = in_if.valid && in_if.ready;
  assign phase_len   = (half_r == '0) ? HALF_W'(1) : half_r;

  always_comb begin
    neg_raw = ~head + CMD_W'(1);
    if (head[CMD_W-1]) begin
      // the most negative count saturates
      mag = neg_raw[CMD_W-1] ? {STEPS_W{1'b1}} : neg_raw[STEPS_W-1:0];
    end else begin
      mag = head[STEPS_W-1:0];
    end
  end

  always_comb begin
    logic [STEPS_W-1:0] st;
    logic [HALF_W-1:0]  ph;
    logic               sl;
    st         = steps_r;
    ph         = phase_r;
    sl         = step_r;
    dir_nxt    = dir_r;
    status     = POST_NONE;
    qctrl.push = 1'b0;
    qctrl.pop  = 1'b0;
    if (in_if.func) begin
      if (!qstat.full) begin
        qctrl.push = in_xfer;
        status     = POST_OK;
      end else begin
        status     = POST_FULL;
      end
    end else begin
      if (st != '0) begin
        if (ph != '0) begin
          ph = ph - HALF_W'(1);
        end
        if (ph == '0) begin
          if (sl) begin
            sl = 1'b0;
            ph = phase_len;
          end else begin
            st = st - STEPS_W'(1);
            if (st != '0) begin
              sl = 1'b1;
              ph = phase_len;
            end
          end
        end
      end
      if (st == '0 && !qstat.empty) begin
        qctrl.pop = in_xfer;
        dir_nxt   = !head[CMD_W-1];
        if (mag != '0) begin
          st = mag;
          sl = 1'b1;
          ph = phase_len;
        end
      end
    end
    steps_nxt = st;
    phase_nxt = ph;
    step_nxt  = sl;
    if (qctrl.push) begin
      empty_after = 1'b0;
    end else if (qctrl.pop) begin
      empty_after = qstat.last;
    end else begin
      empty_after = qstat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r      <= HALF_PERIOD_RESET;
      steps_r     <= '0;
      phase_r     <= '0;
      step_r      <= 1'b0;
      dir_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        half_r <= cfg_wdata;
      end
      if (in_xfer) begin
        steps_r <= steps_nxt;
        phase_r <= phase_nxt;
        step_r  <= step_nxt;
        dir_r   <= dir_nxt;
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_xfer) begin
      o_step_r   <= step_nxt;
      o_dir_r    <= dir_nxt;
      o_status_r <= status;
      o_empty_r  <= empty_after;
      o_busy_r   <= (steps_nxt != '0);
    end
  end

  qsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (qctrl),
    .wdata (in_if.step_count),
    .head  (head),
    .stat  (qstat)
  );

  assign out_if.valid          = out_valid_r;
  assign out_if.step_level     = o_step_r;
  assign out_if.dir_level      = o_dir_r;
  assign out_if.post_status    = o_status_r;
  assign out_if.queue_empty    = o_empty_r;
  assign out_if.generator_busy = o_busy_r;

endmodule

`default_nettype wire

>>> src/qsd_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module qsd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/qsd_queue.sv
// command fifo: ram with a prefetched head and a write bypass
`timescale 1ns / 1ps
`default_nettype none

module qsd_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire qsd_pkg::queue_ctrl_t      ctrl,
  input  wire logic [qsd_pkg::CMD_W-1:0] wdata,
  output logic      [qsd_pkg::CMD_W-1:0] head,
  output qsd_pkg::queue_stat_t           stat
);
  import qsd_pkg::*;

  localparam int unsigned AW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int unsigned FW = $clog2(DEPTH + 1);

  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [FW-1:0]    fill_r, fill_nxt;
  logic             byp_v_r;
  logic [CMD_W-1:0] byp_d_r;
  logic [CMD_W-1:0] ram_q;

  function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_comb begin
    rd_ptr_nxt = ctrl.pop  ? next_ptr(rd_ptr_r) : rd_ptr_r;
    wr_ptr_nxt = ctrl.push ? next_ptr(wr_ptr_r) : wr_ptr_r;
    fill_nxt   = fill_r;
    if (ctrl.push) begin
      fill_nxt = fill_r + FW'(1);
    end else if (ctrl.pop) begin
      fill_nxt = fill_r - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      fill_r   <= '0;
      byp_v_r  <= 1'b0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      fill_r   <= fill_nxt;
      // ram read is read-first, so a write landing on the next head is forwarded
      byp_v_r  <= ctrl.push && (wr_ptr_r == rd_ptr_nxt);
    end
    byp_d_r <= wdata;
  end

  qsd_ram #(
    .WIDTH (CMD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctrl.push),
    .waddr (wr_ptr_r),
    .wdata (wdata),
    .raddr (rd_ptr_nxt),
    .rdata (ram_q)
  );

  assign head       = byp_v_r ? byp_d_r : ram_q;
  assign stat.empty = (fill_r == '0);
  assign stat.full  = (fill_r == FW'(DEPTH));
  assign stat.last  = (fill_r == FW'(1));

endmodule

`default_nettype wire

>>> src/qsd_checker.sv
// port level checks for the pulse generator top, attached by bind
`timescale 1ns / 1ps
`default_nettype none

module qsd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       step_level,
  input wire logic       dir_level,
  input wire logic [1:0] post_status,
  input wire logic       queue_empty,
  input wire logic       generator_busy
);
  import qsd_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(step_level) && $stable(dir_level)
      && $stable(post_status) && $stable(queue_empty) && $stable(generator_busy))
    else $error("result changed while stalled");

  // every input transfer produces a result next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("input transfer without a result");

  // no new input while a result waits and is not taken
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input ready while result is stalled");

  // step line is only high inside a pulse train
  a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !generator_busy |-> !step_level)
    else $error("step high while generator idle");

  // a post, accepted or rejected, leaves the queue non empty
  a_post_queue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (post_status == POST_OK || post_status == POST_FULL) |-> !queue_empty)
    else $error("queue empty after a post");

endmodule

bind queued_step_dir_pulse_generator_top qsd_checker u_qsd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .step_level     (out_if.step_level),
  .dir_level      (out_if.dir_level),
  .post_status    (out_if.post_status),
  .queue_empty    (out_if.queue_empty),
  .generator_busy (out_if.generator_busy)
);

`default_nettype wire
